>>> rtl/ubxfb_pkg.sv
// Shared types and constants for the UBX frame builder.
// No dependencies; every file but ubxfb_if refers to it by scoped names.
package ubxfb_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // One queued request, fully decoded by the front end.
  typedef struct packed {
    logic        is_start;
    logic        with_ck;
    logic [7:0]  first_byte;
    logic [7:0]  msg_id;
    logic [15:0] frame_length;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
  } job_t;

endpackage

>>> rtl/ubxfb_if.sv
// Handshake channel interfaces for the UBX frame builder.
// Depends on nothing; both channels use valid and ready.
interface ubxfb_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] frame_length;
  logic [7:0]  data_byte;

  modport source (output valid, op, msg_class, msg_id, frame_length, data_byte,
                  input ready);
  modport sink (input valid, op, msg_class, msg_id, frame_length, data_byte,
                output ready);
endinterface

interface ubxfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink (input valid, out_byte, run_last, frame_end, output ready);
endinterface

>>> rtl/ubx_frame_builder_unit.sv
// UBX frame builder top level: front end, job queue and byte sequencer.
// Depends on ubxfb_pkg, ubxfb_if, ubxfb_front, ubxfb_queue and ubxfb_back.
//
// Requests arrive on in_ch (valid/ready). A start request (op 0) carries
// class, id and payload length and produces the sync bytes, the four header
// bytes and, for a zero length, the two checksum bytes. A payload request
// (op 1) produces its byte and, on the last byte of the frame, the two
// checksum bytes. A payload request with no open frame is taken and dropped.
// Bytes leave on out_ch one per cycle while the receiver is ready; run_last
// marks the final byte of a request and frame_end the second checksum byte.
// The first byte of a request passes through the job queue and the output
// register before it is presented on out_ch. The front end takes one request
// per cycle while the job queue (QUEUE_DEPTH entries) has room; sustained
// rate is set by the output port at one byte per cycle.
// When the receiver stalls, the output register holds its byte and the queue
// fills; in_ch.ready drops only when the queue is full.
// Synchronous active-low reset empties the queue and output register, closes
// any frame and clears the sums; the block is ready on the next cycle.
module ubx_frame_builder_unit #(
  parameter int QUEUE_DEPTH = ubxfb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  ubxfb_in_if.sink          in_ch,
  ubxfb_out_if.source       out_ch
);

  logic            q_full;
  logic            q_push;
  ubxfb_pkg::job_t q_job;
  logic            q_pop;
  logic            head_valid;
  ubxfb_pkg::job_t head_job;

  ubxfb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_op           (in_ch.op),
    .in_msg_class    (in_ch.msg_class),
    .in_msg_id       (in_ch.msg_id),
    .in_frame_length (in_ch.frame_length),
    .in_data_byte    (in_ch.data_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_job)
  );

  ubxfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ubxfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_run_last  (out_ch.run_last),
    .out_frame_end (out_ch.frame_end)
  );

endmodule

>>> rtl/ubxfb_front.sv
// Front end: accepts requests, keeps the Fletcher sums and frame state,
// and hands decoded jobs to the queue. Depends on ubxfb_pkg.
module ubxfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [7:0]        in_msg_class,
  input  logic [7:0]        in_msg_id,
  input  logic [15:0]       in_frame_length,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              q_push,
  output ubxfb_pkg::job_t   q_job
);

  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        frame_open_r, frame_open_nxt;

  logic [7:0]  hdr_a2, hdr_a3, hdr_a4;
  logic [7:0]  hdr_b2, hdr_b3, hdr_b4;
  logic [7:0]  pay_a, pay_b;
  logic [15:0] left_dec;
  logic        accept;
  logic        is_start;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = (in_op == ubxfb_pkg::OP_START);

  // Header sums: the class byte seeds both sums, then id, length low, length high.
  assign hdr_a2 = in_msg_class + in_msg_id;
  assign hdr_b2 = in_msg_class + hdr_a2;
  assign hdr_a3 = hdr_a2 + in_frame_length[7:0];
  assign hdr_b3 = hdr_b2 + hdr_a3;
  assign hdr_a4 = hdr_a3 + in_frame_length[15:8];
  assign hdr_b4 = hdr_b3 + hdr_a4;

  assign pay_a    = sum_a_r + in_data_byte;
  assign pay_b    = sum_b_r + pay_a;
  assign left_dec = bytes_left_r - 16'd1;

  assign q_push = accept && (is_start || frame_open_r);

  always_comb begin
    q_job.is_start     = is_start;
    q_job.with_ck      = is_start ? (in_frame_length == 16'd0) : (left_dec == 16'd0);
    q_job.first_byte   = is_start ? in_msg_class : in_data_byte;
    q_job.msg_id       = in_msg_id;
    q_job.frame_length = in_frame_length;
    q_job.ck_a         = is_start ? hdr_a4 : pay_a;
    q_job.ck_b         = is_start ? hdr_b4 : pay_b;
  end

  always_comb begin
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    bytes_left_nxt = bytes_left_r;
    frame_open_nxt = frame_open_r;
    if (accept && is_start) begin
      sum_a_nxt      = hdr_a4;
      sum_b_nxt      = hdr_b4;
      bytes_left_nxt = in_frame_length;
      frame_open_nxt = (in_frame_length != 16'd0);
    end else if (accept && frame_open_r) begin
      sum_a_nxt      = pay_a;
      sum_b_nxt      = pay_b;
      bytes_left_nxt = left_dec;
      frame_open_nxt = (left_dec != 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r      <= 8'd0;
      sum_b_r      <= 8'd0;
      bytes_left_r <= 16'd0;
      frame_open_r <= 1'b0;
    end else begin
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      bytes_left_r <= bytes_left_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

  // An open frame always has payload still owed.
  a_open_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> bytes_left_r != 16'd0)
    else $error("open frame with no bytes left");

  // A request that closes the frame is the one that carries the checksum.
  a_close_has_ck: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && $fell(frame_open_nxt) |-> q_job.with_ck)
    else $error("frame closed without checksum");

endmodule

>>> rtl/ubxfb_queue.sv
// Short job queue between the front end and the byte sequencer.
// Depends on ubxfb_pkg for the job type.
module ubxfb_queue #(
  parameter int DEPTH = ubxfb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ubxfb_pkg::job_t   push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ubxfb_pkg::job_t   head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ubxfb_pkg::job_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != CNT_W'(0));
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/ubxfb_back.sv
// Byte sequencer: walks the head job byte by byte into the output register.
// Depends on ubxfb_pkg for the job type and sync constants.
module ubxfb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  ubxfb_pkg::job_t   head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_frame_end
);

  localparam logic [2:0] LAST_HDR    = 3'd5;
  localparam logic [2:0] LAST_HDR_CK = 3'd7;
  localparam logic [2:0] LAST_PAY    = 3'd0;
  localparam logic [2:0] LAST_PAY_CK = 3'd2;

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       run_last_r;
  logic       frame_end_r;
  logic [7:0] sel_byte;
  logic [2:0] last_idx;
  logic       is_last;
  logic       load;

  assign load     = !valid_r || out_ready;
  assign last_idx = head_job.is_start ? (head_job.with_ck ? LAST_HDR_CK : LAST_HDR)
                                      : (head_job.with_ck ? LAST_PAY_CK : LAST_PAY);
  assign is_last  = (idx_r == last_idx);
  assign pop      = load && head_valid && is_last;
  assign idx_nxt  = is_last ? 3'd0 : idx_r + 3'd1;

  always_comb begin
    if (head_job.is_start) begin
      case (idx_r)
        3'd0:    sel_byte = ubxfb_pkg::SYNC_ONE;
        3'd1:    sel_byte = ubxfb_pkg::SYNC_TWO;
        3'd2:    sel_byte = head_job.first_byte;
        3'd3:    sel_byte = head_job.msg_id;
        3'd4:    sel_byte = head_job.frame_length[7:0];
        3'd5:    sel_byte = head_job.frame_length[15:8];
        3'd6:    sel_byte = head_job.ck_a;
        default: sel_byte = head_job.ck_b;
      endcase
    end else begin
      case (idx_r)
        3'd0:    sel_byte = head_job.first_byte;
        3'd1:    sel_byte = head_job.ck_a;
        default: sel_byte = head_job.ck_b;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else if (load) begin
      valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      byte_r      <= sel_byte;
      run_last_r  <= is_last;
      frame_end_r <= is_last && head_job.with_ck;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && frame_end_r |-> run_last_r)
    else $error("frame end not on last byte of request");

  a_mid_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> head_valid)
    else $error("sequencer mid-request with empty queue");

endmodule
